// ----- rtl/sorted_table_binary_search_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table search block
// Shared wrappers around concurrent port checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define STBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stbs port check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define STBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stbs port check failed");

`endif

// ----- rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted key table search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned KEYIN_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // Request commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_SIGNED = 1'b1;

  // Outcome of one key compare
  typedef struct packed {
    logic eq;  // table key equals sought key
    logic gt;  // table key orders above sought key
  } cmp_t;

  // Search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

// ----- rtl/stbs_key_mem.sv -----
// ----------------------------------------------------------------------------
// stbs_key_mem
// Key table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stbs_key_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned KEY_W = 16,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [KEY_W-1:0] rdata_o
);

  logic [KEY_W-1:0] key_mem_q [DEPTH];
  logic [KEY_W-1:0] rdata_q;

  // Write when enabled and read every cycle; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= key_mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stbs_key_cmp.sv -----
// ----------------------------------------------------------------------------
// stbs_key_cmp
// Shared key comparator: equal and greater, unsigned or two's complement.
// ----------------------------------------------------------------------------
module stbs_key_cmp #(
  parameter int unsigned KEY_W = 16
) (
  input  logic             [KEY_W-1:0] table_key_i,
  input  logic             [KEY_W-1:0] want_key_i,
  input  logic                         signed_i,
  output stbs_pkg::cmp_t               res_o
);

  logic [KEY_W-1:0] flip;
  logic [KEY_W-1:0] a_ord;
  logic [KEY_W-1:0] b_ord;

  // Flipping the sign bit turns a signed order into an unsigned one
  assign flip  = KEY_W'(signed_i) << (KEY_W - 1);
  assign a_ord = table_key_i ^ flip;
  assign b_ord = want_key_i ^ flip;

  assign res_o.eq = (a_ord == b_ord);
  assign res_o.gt = (a_ord > b_ord);

endmodule

// ----- rtl/sorted_table_binary_search_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted key table with a halving search, one probe per cycle.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o  | command, entry_index, entry_key,
//          |                          | search_key
//  out     | out_valid_o / out_stall_i| found, match_index
//  cfg     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
//  A write request is stored as it is accepted. A search request is accepted,
//  then probes the table (at most floor(log2(entry_count)) + 1 probes, 9 for a
//  full table of 256), then loads the result register.
//  The probe loop is the key memory read feeding the shared comparator.
//  Reset clears control and configuration; table contents are undefined.
//  A stalled result holds in the output register; a finished search waits
//  until that register is free.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [stbs_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [stbs_pkg::KEYIN_W-1:0]        entry_key_i,
  input  logic [stbs_pkg::KEYIN_W-1:0]        search_key_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [stbs_pkg::IDX_W-1:0]          match_index_o
);

  localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW      = stbs_pkg::CNT_W;
  localparam int unsigned CNT_MAX = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
  localparam logic [CW-1:0] CNT_LIM = CNT_MAX[CW-1:0];

  // Configuration registers
  logic [CW-1:0] count_q;
  logic          signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        stbs_pkg::CFG_ENTRY_COUNT:    count_q  <= cfg_wdata_i[CW-1:0];
        stbs_pkg::CFG_COMPARE_SIGNED: signed_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // First probe of a range: its start when small, else its middle
  function automatic logic [AW-1:0] probe_of(input logic [AW-1:0] lo,
                                             input logic [CW-1:0] n);
    logic [AW-1:0] p;
    if (n <= CW'(2)) begin
      p = lo;
    end else begin
      p = lo + AW'(n >> 1);
    end
    return p;
  endfunction

  // Sequencer state
  stbs_pkg::state_e     state_q, state_d;
  logic [AW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        n_q, n_d;
  logic [AW-1:0]        probe_q, probe_d;
  logic [KEY_WIDTH-1:0] want_q, want_d;
  logic                 hit_q, hit_d;
  logic [AW-1:0]        where_q, where_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q;
  logic [stbs_pkg::IDX_W-1:0] out_index_q;

  logic                 in_accept;
  logic                 mem_we;
  logic [CW-1:0]        n_start;
  logic [CW-1:0]        md;
  logic [KEY_WIDTH-1:0] rdata;
  stbs_pkg::cmp_t       cmp;
  logic                 out_free;
  logic                 out_load;

  assign in_stall_o = (state_q != stbs_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mem_we     = in_accept && (command_i == stbs_pkg::CMD_WRITE) &&
                      (32'(entry_index_i) < TABLE_DEPTH);
  assign n_start    = (count_q > CNT_LIM) ? CNT_LIM : count_q;
  assign md         = n_q >> 1;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == stbs_pkg::ST_FINISH) && out_free;

  // Key table
  stbs_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (KEY_WIDTH'(entry_key_i)),
    .raddr_i (probe_d),
    .rdata_o (rdata)
  );

  // Shared comparator
  stbs_key_cmp #(
    .KEY_W (KEY_WIDTH)
  ) u_cmp (
    .table_key_i (rdata),
    .want_key_i  (want_q),
    .signed_i    (signed_q),
    .res_o       (cmp)
  );

  // Search sequencer: one probe compared and the next issued each cycle
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    n_d     = n_q;
    probe_d = probe_q;
    want_d  = want_q;
    hit_d   = hit_q;
    where_d = where_q;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (in_accept && (command_i == stbs_pkg::CMD_SEARCH)) begin
          want_d  = KEY_WIDTH'(search_key_i);
          lo_d    = '0;
          n_d     = n_start;
          probe_d = probe_of('0, n_start);
          hit_d   = 1'b0;
          where_d = '0;
          // empty table: nothing to read
          state_d = (n_start == '0) ? stbs_pkg::ST_FINISH : stbs_pkg::ST_RUN;
        end
      end
      stbs_pkg::ST_RUN: begin
        if (cmp.eq) begin
          hit_d   = 1'b1;
          where_d = probe_q;
          state_d = stbs_pkg::ST_FINISH;
        end else if (n_q <= CW'(2)) begin
          // small range: step to its second entry, or give up
          if (n_q == CW'(2)) begin
            lo_d    = lo_q + AW'(1);
            n_d     = CW'(1);
            probe_d = lo_q + AW'(1);
          end else begin
            state_d = stbs_pkg::ST_FINISH;
          end
        end else begin
          // keep the lower or the upper part of the range
          if (cmp.gt) begin
            n_d = md;
          end else begin
            lo_d = probe_q + AW'(1);
            n_d  = n_q - md - CW'(1);
          end
          probe_d = probe_of(lo_d, n_d);
        end
      end
      stbs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    n_q     <= n_d;
    probe_q <= probe_d;
    want_q  <= want_d;
    hit_q   <= hit_d;
    where_q <= where_d;
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= hit_q;
      out_index_q <= stbs_pkg::IDX_W'(where_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign match_index_o = out_index_q;

endmodule

// ----- rtl/stbs_port_chk.sv -----
// ----------------------------------------------------------------------------
// stbs_port_chk
// Port-level checks for the sorted key table search block.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_top_assert.svh"

module stbs_port_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         command_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         found_o,
  input logic [stbs_pkg::IDX_W-1:0]   match_index_o
);

  logic search_req;
  logic write_req;

  assign search_req = in_valid_i && !in_stall_o && (command_i == stbs_pkg::CMD_SEARCH);
  assign write_req  = in_valid_i && !in_stall_o && (command_i == stbs_pkg::CMD_WRITE);

  // a miss always reports index zero
  `STBS_ASSERT_NOW(a_miss_index_zero, out_valid_o && !found_o, match_index_o == '0)

  // a search holds off further requests while it runs
  `STBS_ASSERT_NEXT(a_search_busy, search_req, in_stall_o)

  // a table write completes at once and leaves the block open
  `STBS_ASSERT_NEXT(a_write_no_busy, write_req, !in_stall_o)

  // a stalled result stays offered
  `STBS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind sorted_table_binary_search_top stbs_port_chk u_stbs_port_chk (.*);
